/* sv/prt_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// prt_pkg
// Shared types and codes for the permutation reversal and transposition block.
// ---------------------------------------------------------------------------
package prt_pkg;

  // Width of an internal position counter (positions run up to 127).
  localparam int POS_W = 8;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM_LENGTH   = 1'b1;

  // Operation codes.
  localparam logic [1:0] OP_IDENT = 2'd0;
  localparam logic [1:0] OP_REV   = 2'd1;
  localparam logic [1:0] OP_TRANS = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Input beat.
  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] start_pos;
    logic [6:0] second_pos;
    logic [6:0] stop_pos;
    logic [6:0] read_pos;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic signed [7:0] read_value;
    logic              op_error;
  } out_beat_t;

  // Control from the sequencer to the element store.
  typedef struct packed {
    logic fill_start;
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

endpackage : prt_pkg
`default_nettype wire

/* sv/prt_store.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// prt_store
// Element memory with two registered read ports, one write port and an
// identity fill sweep that runs after reset and on request.
// ---------------------------------------------------------------------------
module prt_store #(
  parameter int MAX_LEN = 64,
  localparam int AW = $clog2(MAX_LEN),
  localparam int DW = AW + 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire prt_pkg::store_ctl_t    ctl,
  input  wire logic [AW-1:0]          rd_addr_a,
  input  wire logic [AW-1:0]          rd_addr_b,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic signed [DW-1:0]   wr_data,
  output logic signed [DW-1:0]        rd_data_a,
  output logic signed [DW-1:0]        rd_data_b,
  output logic                        fill_busy
);
  import prt_pkg::*;

  logic signed [DW-1:0] mem [MAX_LEN];
  logic signed [DW-1:0] rd_a_r;
  logic signed [DW-1:0] rd_b_r;
  logic                 fill_busy_r;
  logic [AW-1:0]        fill_cnt_r;
  logic                 fill_last;

  assign fill_last = (fill_cnt_r == AW'(MAX_LEN - 1));

  // Fill sweep: one entry per cycle, entry k receives k plus one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_cnt_r  <= '0;
    end else if (fill_busy_r) begin
      fill_cnt_r <= fill_cnt_r + 1'b1;
      if (fill_last) begin
        fill_busy_r <= 1'b0;
      end
    end else if (ctl.fill_start) begin
      fill_busy_r <= 1'b1;
      fill_cnt_r  <= '0;
    end
  end

  // Write port; the sweep takes priority over the sequencer.
  always_ff @(posedge clk) begin
    if (fill_busy_r) begin
      mem[fill_cnt_r] <= DW'(fill_cnt_r) + 1'b1;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Both read ports register their data; the data holds while idle.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;
  assign fill_busy = fill_busy_r;

endmodule : prt_store
`default_nettype wire

/* sv/permutation_reversal_transposition_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// permutation_reversal_transposition_top
// Keeps a signed permutation in memory and applies segment reversals,
// adjacent block swaps, identity restores and reads to it.
// ---------------------------------------------------------------------------
// Usage: one command beat enters on in_valid/in_ready and produces exactly one
// result beat on out_valid/out_ready. The user must write registers on the cfg_
// port only while the block is idle; the block itself does not enforce this.
// A reversal of n positions swaps element pairs in place: one read of both
// ends, then one write per element. A block swap is done as three reversals
// without negation. The single write port of the element memory limits the
// work to one element per cycle. After reset the memory is filled with the
// identity and in_ready stays low until that sweep ends.
// The result sits in an output register; a new command is taken while it
// waits. If the receiver stalls, the next result is held inside until the
// register frees, and no further command is taken meanwhile.
// ---------------------------------------------------------------------------
module permutation_reversal_transposition_top #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire prt_pkg::in_beat_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output prt_pkg::out_beat_t                      out_data,
  input  wire logic                               cfg_we,
  input  wire logic [prt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [prt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import prt_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int DW = AW + 2;

  typedef enum logic [8:0] {
    ST_BOOT  = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_CLR   = 9'b000000100,
    ST_SEG   = 9'b000001000,
    ST_RD    = 9'b000010000,
    ST_WA    = 9'b000100000,
    ST_WB    = 9'b001000000,
    ST_RREAD = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  // Position to memory index: position p lives at entry p minus one.
  function automatic logic [AW-1:0] pos_idx(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] q;
    q = p - 1'b1;
    return AW'(q);
  endfunction

  state_t               state_r;
  state_t               state_nxt;
  logic                 unsigned_mode_r;
  logic [6:0]           perm_length_r;
  logic [6:0]           len;
  logic                 in_acc;
  logic                 rev_ok;
  logic                 trans_ok;
  logic                 read_ok;
  logic                 cmd_ok;
  logic [1:0]           op_r;
  logic [6:0]           s_r;
  logic [6:0]           m_r;
  logic [6:0]           e_r;
  logic                 neg_r;
  logic [1:0]           seg_r;
  logic [POS_W-1:0]     lo_r;
  logic [POS_W-1:0]     hi_r;
  logic [POS_W-1:0]     seg_lo;
  logic [POS_W-1:0]     seg_hi;
  logic                 last_seg;
  logic                 more_pairs;
  logic signed [7:0]    res_val_r;
  logic                 res_err_r;
  logic                 out_valid_r;
  out_beat_t            out_data_r;
  logic                 out_free;
  store_ctl_t           st_ctl;
  logic [AW-1:0]        rd_addr_a;
  logic [AW-1:0]        rd_addr_b;
  logic [AW-1:0]        wr_addr;
  logic signed [DW-1:0] wr_data;
  logic signed [DW-1:0] rd_data_a;
  logic signed [DW-1:0] rd_data_b;
  logic signed [DW-1:0] mv_a;
  logic signed [DW-1:0] mv_b;
  logic signed [31:0]   rd_ext;
  logic                 fill_busy;

  // Element memory.
  prt_store #(
    .MAX_LEN (MAX_LEN)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (st_ctl),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .fill_busy (fill_busy)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unsigned_mode_r <= 1'b1;
      perm_length_r   <= 7'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNSIGNED_MODE: unsigned_mode_r <= cfg_wdata[0];
        CFG_PERM_LENGTH:   perm_length_r   <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  // Effective length, saturated to the memory depth.
  assign len = (32'(perm_length_r) > MAX_LEN) ? 7'(MAX_LEN) : perm_length_r;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Index checks on the incoming beat.
  assign rev_ok   = (in_data.start_pos != 7'd0) &&
                    (in_data.start_pos <= in_data.second_pos) &&
                    (in_data.second_pos <= len);
  assign trans_ok = (in_data.start_pos != 7'd0) &&
                    (in_data.start_pos <= in_data.second_pos) &&
                    (in_data.second_pos <= in_data.stop_pos) &&
                    ({1'b0, in_data.stop_pos} <= ({1'b0, len} + 8'd1));
  assign read_ok  = (in_data.read_pos != 7'd0) && (in_data.read_pos <= len);

  always_comb begin
    unique case (in_data.opcode)
      OP_IDENT: cmd_ok = 1'b1;
      OP_REV:   cmd_ok = rev_ok;
      OP_TRANS: cmd_ok = trans_ok;
      OP_READ:  cmd_ok = read_ok;
      default:  cmd_ok = 1'b0;
    endcase
  end

  // Segment bounds: a block swap is three reversals in turn.
  always_comb begin
    seg_lo   = {1'b0, s_r};
    seg_hi   = {1'b0, m_r};
    last_seg = 1'b1;
    if (op_r == OP_TRANS) begin
      last_seg = (seg_r == 2'd2);
      unique case (seg_r)
        2'd0: begin
          seg_lo = {1'b0, s_r};
          seg_hi = {1'b0, m_r} - 8'd1;
        end
        2'd1: begin
          seg_lo = {1'b0, m_r};
          seg_hi = {1'b0, e_r} - 8'd1;
        end
        default: begin
          seg_lo = {1'b0, s_r};
          seg_hi = {1'b0, e_r} - 8'd1;
        end
      endcase
    end
  end

  // Moved elements, negated for a reversal in signed mode.
  assign mv_a       = neg_r ? -rd_data_a : rd_data_a;
  assign mv_b       = neg_r ? -rd_data_b : rd_data_b;
  assign more_pairs = ((lo_r + 8'd2) <= hi_r);
  assign rd_ext     = 32'(rd_data_a);

  // Sequencer: next state and memory control.
  always_comb begin
    state_nxt     = state_r;
    st_ctl        = '0;
    rd_addr_a     = pos_idx(lo_r);
    rd_addr_b     = pos_idx(hi_r);
    wr_addr       = pos_idx(lo_r);
    wr_data       = mv_b;
    unique case (state_r)
      ST_BOOT: begin
        if (!fill_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (!cmd_ok) begin
            state_nxt = ST_FIN;
          end else begin
            unique case (in_data.opcode)
              OP_IDENT: begin
                st_ctl.fill_start = 1'b1;
                state_nxt         = ST_CLR;
              end
              OP_READ: begin
                st_ctl.rd_en = 1'b1;
                rd_addr_a    = pos_idx({1'b0, in_data.read_pos});
                state_nxt    = ST_RREAD;
              end
              default: state_nxt = ST_SEG;
            endcase
          end
        end
      end
      ST_CLR: begin
        if (!fill_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_SEG: begin
        if (seg_lo > seg_hi) begin
          state_nxt = last_seg ? ST_FIN : ST_SEG;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        st_ctl.rd_en = 1'b1;
        state_nxt    = ST_WA;
      end
      ST_WA: begin
        st_ctl.wr_en = 1'b1;
        if (lo_r == hi_r) begin
          state_nxt = last_seg ? ST_FIN : ST_SEG;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        st_ctl.wr_en = 1'b1;
        wr_addr      = pos_idx(hi_r);
        wr_data      = mv_a;
        if (more_pairs) begin
          st_ctl.rd_en = 1'b1;
          rd_addr_a    = pos_idx(lo_r + 8'd1);
          rd_addr_b    = pos_idx(hi_r - 8'd1);
          state_nxt    = ST_WA;
        end else begin
          state_nxt = last_seg ? ST_FIN : ST_SEG;
        end
      end
      ST_RREAD: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BOOT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command, pointer and result registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_r      <= in_data.opcode;
          s_r       <= in_data.start_pos;
          m_r       <= in_data.second_pos;
          e_r       <= in_data.stop_pos;
          neg_r     <= (in_data.opcode == OP_REV) && !unsigned_mode_r;
          seg_r     <= 2'd0;
          res_val_r <= '0;
          res_err_r <= !cmd_ok;
        end
      end
      ST_SEG: begin
        lo_r <= seg_lo;
        hi_r <= seg_hi;
        if (seg_lo > seg_hi) begin
          seg_r <= seg_r + 2'd1;
        end
      end
      ST_WA: begin
        if (lo_r == hi_r) begin
          seg_r <= seg_r + 2'd1;
        end
      end
      ST_WB: begin
        lo_r <= lo_r + 8'd1;
        hi_r <= hi_r - 8'd1;
        if (!more_pairs) begin
          seg_r <= seg_r + 2'd1;
        end
      end
      ST_RREAD: begin
        res_val_r <= rd_ext[7:0];
      end
      default: ;
    endcase
  end

  // Output register: one result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_data_r.read_value <= res_val_r;
      out_data_r.op_error   <= res_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : permutation_reversal_transposition_top
`default_nettype wire
